// ----- rtl/assert_macros.svh -----
// Assertion macros for the checker file.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is held.
`define ASSERT_RST(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// Clocked assertion checked at every edge, reset included.
`define ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) else $error("assertion failed");

`endif

// ----- rtl/pfa_pkg.sv -----
// Package of the page frame allocator: sizes, codes, request and response types.
// No dependencies.
package pfa_pkg;

  localparam int PageCount  = 65536;
  localparam int UsageKinds = 8;
  localparam int MaxRun     = 256;

  localparam int PageAw = $clog2(PageCount);
  localparam int CntW   = PageAw + 1;
  localparam int IdxW   = 16;
  localparam int TagW   = 3;
  localparam int LenW   = 9;
  localparam int StatW  = 17;
  localparam int EntW   = TagW + 1;

  localparam logic [IdxW-1:0] LowPageRst = 16'd256;
  localparam logic RegLowPage = 1'b0;

  typedef enum logic [2:0] {
    CmdAllocPage = 3'd0,
    CmdAllocRun  = 3'd1,
    CmdFreePage  = 3'd2,
    CmdAddPage   = 3'd3,
    CmdStats     = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StNoSpace  = 2'd1,
    StNotAlloc = 2'd2,
    StBadUsage = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]      command;
    logic [TagW-1:0] usage;
    logic [IdxW-1:0] page_index;
    logic [LenW-1:0] run_length;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IdxW-1:0]  result_page;
    logic [StatW-1:0] usage_pages;
    logic [StatW-1:0] free_pages;
    logic [StatW-1:0] total_pages;
  } rsp_t;

  // Counter update requested by the control logic.
  typedef struct packed {
    logic            take;
    logic            give;
    logic            add;
    logic [TagW-1:0] tag;
  } st_op_t;

  function automatic logic usage_ok(logic [TagW-1:0] u);
    return (u != '0) && (32'(u) < UsageKinds);
  endfunction

endpackage

// ----- rtl/pfa_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pfa_ram #(
  parameter int Depth = 1024,
  parameter int Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- rtl/pfa_stats.sv -----
// Per-usage page counters plus free and total page counts.
// Depends on pfa_pkg.
module pfa_stats import pfa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  st_op_t           op_i,
  output logic [StatW-1:0] usage_o,
  output logic [StatW-1:0] free_o,
  output logic [StatW-1:0] total_o
);

  logic [StatW-1:0] cnt_q [2**TagW];
  logic [StatW-1:0] cnt_d;
  logic [StatW-1:0] free_q, free_d, total_q, total_d;

  assign usage_o = cnt_q[op_i.tag];
  assign free_o  = free_q;
  assign total_o = total_q;

  always_comb begin
    cnt_d   = cnt_q[op_i.tag];
    free_d  = free_q;
    total_d = total_q;
    if (op_i.take) begin
      cnt_d = cnt_q[op_i.tag] + 1'b1;
      if (free_q != '0) free_d = free_q - 1'b1;
    end
    if (op_i.give) begin
      if (cnt_q[op_i.tag] != '0) cnt_d = cnt_q[op_i.tag] - 1'b1;
      free_d = free_q + 1'b1;
    end
    if (op_i.add) begin
      free_d  = free_q + 1'b1;
      total_d = total_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2**TagW; i++) cnt_q[i] <= '0;
      free_q  <= '0;
      total_q <= '0;
    end else begin
      cnt_q[op_i.tag] <= cnt_d;
      free_q  <= free_d;
      total_q <= total_d;
    end
  end

endmodule

// ----- rtl/page_frame_allocator.sv -----
// Page frame allocator top level: control sequencer, page table RAM, counters.
// Depends on pfa_pkg, pfa_ram and pfa_stats.
//
// Usage
//   Requests enter on in_valid_i/in_ready_o with an req_t payload; one response
//   per request leaves on out_valid_o/out_ready_i as an rsp_t. Requests are
//   handled one at a time; in_ready_o is high whenever the sequencer is idle,
//   even while the previous response still waits in the output register.
//   Steps: free and add page read the entry (SEntry), then respond (SDone).
//   Stats, unused commands and requests rejected up front (bad usage, bad run
//   length) go straight to SDone. Alloc page scans from low_page up to the
//   page found (or the whole range up to the last page when none is free).
//   Alloc run scans up to the last page of the run found (the last page of
//   the table when none fits), then writes the run (SFill). The page table RAM
//   reads one page per cycle, so the scan dominates the time of an allocation.
//   Reset: every page starts allocated with tag 0 (not present); counters
//   clear. A clearing pass then writes the page table, one entry per cycle,
//   covering all PageCount (65536) entries, with in_ready_o low; low_page may be
//   written meanwhile over APB (address 0, reset value 256).
//   Stall: when out_ready_i is low the response holds; the block finishes the
//   next request and then waits for the output register to drain. The user
//   must write configuration only while the block is idle; nothing enforces it.
module page_frame_allocator import pfa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  req_t        in_req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output rsp_t        out_rsp_o
);

  typedef enum logic [5:0] {
    SClear = 6'b000001,
    SIdle  = 6'b000010,
    SScan  = 6'b000100,
    SFill  = 6'b001000,
    SEntry = 6'b010000,
    SDone  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Configuration register
  logic [IdxW-1:0] low_page_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegLowPage) ? {16'b0, low_page_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_page_q <= LowPageRst;
    end else if (psel && penable && pwrite && (paddr[2] == RegLowPage)) begin
      low_page_q <= pwdata[IdxW-1:0];
    end
  end

  // Request context and scan state
  logic [2:0]        cmd_q, cmd_d;
  logic [TagW-1:0]   usage_q, usage_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [1:0]        status_q, status_d;
  logic [IdxW-1:0]   page_q, page_d;
  logic [CntW-1:0]   scan_q, scan_d, chk_q, chk_d, wr_q, wr_d;
  logic [LenW-1:0]   run_q, run_d, left_q, left_d;
  logic [PageAw-1:0] clr_q, clr_d;
  logic              out_valid_q, out_valid_d;
  rsp_t              out_q, out_d;

  // Page table: bit 3 = free, bits 2:0 = usage tag. All zero = reserved.
  logic              ram_we;
  logic [PageAw-1:0] ram_wa, ram_ra;
  logic [EntW-1:0]   ram_wd, ram_rd;

  st_op_t           st_op;
  logic [StatW-1:0] st_usage, st_free, st_total;
  logic [CntW-1:0]  start;
  logic             last;

  pfa_ram #(.Depth(PageCount), .Width(EntW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_wa),
    .wdata_i (ram_wd),
    .raddr_i (ram_ra),
    .rdata_o (ram_rd)
  );

  pfa_stats u_stats (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .op_i    (st_op),
    .usage_o (st_usage),
    .free_o  (st_free),
    .total_o (st_total)
  );

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;
  assign last  = (chk_q == CntW'(PageCount - 1));
  assign start = chk_q - CntW'(len_q) + CntW'(1);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    usage_d     = usage_q;
    idx_d       = idx_q;
    len_d       = len_q;
    status_d    = status_q;
    page_d      = page_q;
    scan_d      = scan_q;
    chk_d       = chk_q;
    wr_d        = wr_q;
    run_d       = run_q;
    left_d      = left_q;
    clr_d       = clr_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    ram_we      = 1'b0;
    ram_wa      = clr_q;
    ram_wd      = '0;
    ram_ra      = scan_q[PageAw-1:0];
    st_op       = '0;
    st_op.tag   = usage_q;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    case (state_q)
      SClear: begin
        ram_we = 1'b1;
        clr_d  = clr_q + 1'b1;
        if (clr_q == PageAw'(PageCount - 1)) state_d = SIdle;
      end

      SIdle: begin
        // Issue the first read for either command family right away.
        if (in_req_i.command == CmdFreePage || in_req_i.command == CmdAddPage) begin
          ram_ra = PageAw'(in_req_i.page_index);
        end else begin
          ram_ra = PageAw'(low_page_q);
        end
        if (in_valid_i) begin
          cmd_d    = in_req_i.command;
          usage_d  = in_req_i.usage;
          idx_d    = in_req_i.page_index;
          len_d    = in_req_i.run_length;
          status_d = StOk;
          page_d   = '0;
          chk_d    = CntW'(low_page_q);
          scan_d   = CntW'(low_page_q) + CntW'(1);
          run_d    = '0;
          state_d  = SDone;
          case (cmd_e'(in_req_i.command))
            CmdAllocPage: begin
              if (!usage_ok(in_req_i.usage)) status_d = StBadUsage;
              else if (32'(low_page_q) >= PageCount) status_d = StNoSpace;
              else state_d = SScan;
            end
            CmdAllocRun: begin
              if (!usage_ok(in_req_i.usage)) status_d = StBadUsage;
              else if (in_req_i.run_length == '0 || 32'(in_req_i.run_length) > MaxRun
                       || 32'(in_req_i.run_length) >= PageCount
                       || 32'(low_page_q) >= PageCount) status_d = StNoSpace;
              else state_d = SScan;
            end
            CmdFreePage: begin
              if (32'(in_req_i.page_index) >= PageCount) status_d = StNotAlloc;
              else state_d = SEntry;
            end
            CmdAddPage: begin
              if (32'(in_req_i.page_index) >= PageCount) status_d = StNoSpace;
              else state_d = SEntry;
            end
            CmdStats: begin
              if (!usage_ok(in_req_i.usage)) status_d = StBadUsage;
            end
            default: ;
          endcase
        end
      end

      SScan: begin
        // ram_rd holds the entry of chk_q; keep the read one page ahead.
        scan_d = scan_q + 1'b1;
        chk_d  = chk_q + 1'b1;
        if (cmd_q == CmdAllocPage) begin
          if (ram_rd[TagW]) begin
            ram_we     = 1'b1;
            ram_wa     = chk_q[PageAw-1:0];
            ram_wd     = {1'b0, usage_q};
            st_op.take = 1'b1;
            page_d     = IdxW'(chk_q);
            state_d    = SDone;
          end else if (last) begin
            status_d = StNoSpace;
            state_d  = SDone;
          end
        end else begin
          if (last) begin
            // A run ending on the last page starts beyond the allowed range.
            status_d = StNoSpace;
            state_d  = SDone;
          end else if (!ram_rd[TagW]) begin
            run_d = '0;
          end else if (run_q + 1'b1 == len_q) begin
            wr_d    = start;
            left_d  = len_q;
            page_d  = IdxW'(start);
            state_d = SFill;
          end else begin
            run_d = run_q + 1'b1;
          end
        end
      end

      SFill: begin
        ram_we     = 1'b1;
        ram_wa     = wr_q[PageAw-1:0];
        ram_wd     = {1'b0, usage_q};
        st_op.take = 1'b1;
        wr_d       = wr_q + 1'b1;
        left_d     = left_q - 1'b1;
        if (left_q == LenW'(1)) state_d = SDone;
      end

      SEntry: begin
        state_d = SDone;
        if (cmd_q == CmdFreePage) begin
          if (ram_rd[TagW] || ram_rd[TagW-1:0] == '0
              || 32'(ram_rd[TagW-1:0]) >= UsageKinds) begin
            status_d = StNotAlloc;
          end else begin
            ram_we     = 1'b1;
            ram_wa     = PageAw'(idx_q);
            ram_wd     = {1'b1, {TagW{1'b0}}};
            st_op.give = 1'b1;
            st_op.tag  = ram_rd[TagW-1:0];
          end
        end else if (!ram_rd[TagW] && ram_rd[TagW-1:0] == '0) begin
          ram_we    = 1'b1;
          ram_wa    = PageAw'(idx_q);
          ram_wd    = {1'b1, {TagW{1'b0}}};
          st_op.add = 1'b1;
        end
      end

      SDone: begin
        // Load the response once the output register is free.
        if (!out_valid_q || out_ready_i) begin
          out_d.status      = status_q;
          out_d.result_page = page_q;
          out_d.usage_pages = usage_ok(usage_q) ? st_usage : '0;
          out_d.free_pages  = st_free;
          out_d.total_pages = st_total;
          out_valid_d       = 1'b1;
          state_d           = SIdle;
        end
      end

      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClear;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    usage_q  <= usage_d;
    idx_q    <= idx_d;
    len_q    <= len_d;
    status_q <= status_d;
    page_q   <= page_d;
    scan_q   <= scan_d;
    chk_q    <= chk_d;
    wr_q     <= wr_d;
    run_q    <= run_d;
    left_q   <= left_d;
    out_q    <= out_d;
  end

endmodule

// ----- rtl/pfa_checker.sv -----
// Port-level checker for the page frame allocator, bound to the top level.
// Depends on pfa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pfa_checker import pfa_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input rsp_t out_rsp_o
);

  // A stalled response holds its payload.
  `ASSERT_RST(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))

  // Only one request is in work at a time.
  `ASSERT_RST(a_one_req, in_valid_i && in_ready_o |=> !in_ready_o)

  // Failed requests report page zero.
  `ASSERT_ALWAYS(a_fail_page, out_valid_o && out_rsp_o.status != StOk |-> out_rsp_o.result_page == '0)

  // Free pages never exceed usable pages.
  `ASSERT_ALWAYS(a_free_le_total, out_valid_o |-> out_rsp_o.free_pages <= out_rsp_o.total_pages)

endmodule

bind page_frame_allocator pfa_checker u_pfa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);

// ----- tb/page_frame_allocator_tb.sv -----
// Testbench for the page frame allocator: a directed table, then random phases over
// several low_page settings, checked against a built-in model of the page table.
// Depends on pfa_pkg and the page_frame_allocator RTL.
`timescale 1ns / 100ps

module page_frame_allocator_tb;
  import pfa_pkg::*;

  localparam int  WatchdogLimit = 300000;
  localparam int  CostlyScan    = 3000;
  localparam int  Window        = 400;
  localparam int  ReportMax     = 10;
  localparam logic [2:0] LowPageAddr = 3'(RegLowPage) * 3'd4;

  // Unused command codes, outside cmd_e.
  localparam logic [2:0] CmdSpare5 = 3'd5;
  localparam logic [2:0] CmdSpare6 = 3'd6;
  localparam logic [2:0] CmdSpare7 = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        in_valid, in_ready;
  req_t        in_req;
  logic        out_valid, out_ready;
  rsp_t        out_rsp;

  page_frame_allocator i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_rsp_o  (out_rsp)
  );

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  // ---------------------------------------------------------------------------
  // Page table model: allocated bit and tag per page, counters, low bound.
  // ---------------------------------------------------------------------------
  bit               page_taken [PageCount];
  logic [TagW-1:0]  page_tag   [PageCount];
  logic [StatW-1:0] tag_pages  [UsageKinds];
  logic [StatW-1:0] free_total;
  logic [StatW-1:0] usable_total;
  logic [IdxW-1:0]  base_page;

  rsp_t             pending_rsps[$];   // responses still owed by the block
  int unsigned      held_pages[$];     // pages the model believes are in use

  int unsigned mismatches;
  int unsigned idle_cycles;
  int unsigned costly_left;            // full-range scans still allowed
  bit          no_stall;               // stretch with no receiver stalls
  bit          no_gap;                 // stretch with no sender gaps

  function automatic bit tag_valid(logic [TagW-1:0] u);
    return (u != '0) && (int'(u) < UsageKinds);
  endfunction

  function automatic void claim_page(int unsigned p, logic [TagW-1:0] u);
    page_taken[p] = 1'b1;
    page_tag[p]   = u;
    tag_pages[u]++;
    if (free_total != '0) free_total--;
    held_pages.push_back(p);
  endfunction

  // Work out the response to one request and advance the model.
  function automatic rsp_t apply_request(req_t r);
    rsp_t        rsp;
    int unsigned run, first, limit;
    int unsigned len;
    bit          ok_tag;
    rsp    = '0;
    ok_tag = tag_valid(r.usage);
    len    = r.run_length;
    rsp.status = StOk;
    case (r.command)
      CmdAllocPage: begin
        if (!ok_tag) rsp.status = StBadUsage;
        else begin
          rsp.status = StNoSpace;
          for (int unsigned i = base_page; i < PageCount; i++) begin
            if (!page_taken[i]) begin
              claim_page(i, r.usage);
              rsp.result_page = i[IdxW-1:0];
              rsp.status      = StOk;
              break;
            end
          end
        end
      end
      CmdAllocRun: begin
        if (!ok_tag) rsp.status = StBadUsage;
        else begin
          rsp.status = StNoSpace;
          if (len != 0 && len <= MaxRun && len < PageCount) begin
            limit = PageCount - len;
            run   = 0;
            for (int unsigned j = base_page; j < PageCount; j++) begin
              if (page_taken[j]) begin
                run = 0;
                continue;
              end
              run++;
              if (run < len) continue;
              first = j - len + 1;
              if (first >= limit) break;
              for (int unsigned k = first; k < first + len; k++) claim_page(k, r.usage);
              rsp.result_page = first[IdxW-1:0];
              rsp.status      = StOk;
              break;
            end
          end
        end
      end
      CmdFreePage: begin
        if (!page_taken[r.page_index] || page_tag[r.page_index] == '0 ||
            int'(page_tag[r.page_index]) >= UsageKinds) begin
          rsp.status = StNotAlloc;
        end else begin
          if (tag_pages[page_tag[r.page_index]] != '0) tag_pages[page_tag[r.page_index]]--;
          free_total++;
          page_taken[r.page_index] = 1'b0;
          page_tag[r.page_index]   = '0;
        end
      end
      CmdAddPage: begin
        if (page_taken[r.page_index] && page_tag[r.page_index] == '0) begin
          page_taken[r.page_index] = 1'b0;
          usable_total++;
          free_total++;
        end
      end
      CmdStats: begin
        if (!ok_tag) rsp.status = StBadUsage;
      end
      default: ;
    endcase
    rsp.usage_pages = ok_tag ? tag_pages[r.usage] : '0;
    rsp.free_pages  = free_total;
    rsp.total_pages = usable_total;
    return rsp;
  endfunction

  // Number of pages an allocation would walk, without changing the model.
  function automatic int unsigned scan_span(req_t r);
    int unsigned run;
    int unsigned len;
    len = r.run_length;
    run = 0;
    if (!tag_valid(r.usage)) return 0;
    if (r.command == CmdAllocPage) begin
      for (int unsigned i = base_page; i < PageCount; i++)
        if (!page_taken[i]) return i - base_page;
      return PageCount - base_page;
    end
    if (r.command != CmdAllocRun || len == 0 || len > MaxRun) return 0;
    for (int unsigned j = base_page; j < PageCount; j++) begin
      if (page_taken[j]) run = 0;
      else run++;
      if (run >= len) return j - base_page;
    end
    return PageCount - base_page;
  endfunction

  // ---------------------------------------------------------------------------
  // Gap lengths: mostly short, a few long.
  // ---------------------------------------------------------------------------
  function automatic int unsigned pick_gap(bit quiet);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 50) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Request side: hold valid and payload until the handshake completes.
  // ---------------------------------------------------------------------------
  task automatic send_request(req_t r, rsp_t typed_rsp, bit typed);
    int unsigned gap;
    rsp_t        predicted;
    gap = pick_gap(no_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (!in_ready);
    predicted = apply_request(r);
    pending_rsps.push_back(typed ? typed_rsp : predicted);
  endtask

  task automatic drain_responses();
    in_valid <= 1'b0;
    wait (pending_rsps.size() == 0);
    // Let the sequencer settle before touching configuration.
    repeat (10) @(posedge clk);
  endtask

  task automatic write_low_page(logic [IdxW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LowPageAddr;
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    base_page = value;
  endtask

  // ---------------------------------------------------------------------------
  // Response side: random stalls, check every accepted response in order.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned n;
    out_ready = 1'b0;
    forever begin
      n = pick_gap(no_stall);
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (out_valid && out_ready) begin
      if (pending_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("%0t: response with nothing outstanding: %p", $realtime, out_rsp);
      end else begin
        want = pending_rsps.pop_front();
        if (out_rsp.status != want.status || out_rsp.result_page != want.result_page ||
            out_rsp.usage_pages != want.usage_pages ||
            out_rsp.free_pages != want.free_pages ||
            out_rsp.total_pages != want.total_pages) begin
          mismatches++;
          if (mismatches <= ReportMax)
            $display("%0t: mismatch expected %p actual %p", $realtime, want, out_rsp);
        end
      end
    end
  end

  // Watchdog: end the run once nothing has moved for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WatchdogLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  typedef struct {
    req_t req;
    bit   typed;
    rsp_t rsp;
  } dir_row_t;

  function automatic dir_row_t row(logic [2:0] c, logic [TagW-1:0] u, int unsigned idx,
                                   int unsigned len, bit typed = 1'b0, rsp_t rsp = '0);
    dir_row_t d;
    d.req   = '{command: c, usage: u, page_index: idx[IdxW-1:0],
                run_length: len[LenW-1:0]};
    d.typed = typed;
    d.rsp   = rsp;
    return d;
  endfunction

  function automatic req_t random_request();
    req_t        r;
    int unsigned roll, span;
    r.usage      = ($urandom_range(0, 19) == 0) ? '0 : TagW'($urandom_range(1, UsageKinds - 1));
    r.page_index = IdxW'($urandom);
    r.run_length = LenW'($urandom_range(1, 8));
    roll = $urandom_range(0, 99);
    if (roll < 25) begin
      r.command    = CmdAddPage;
      r.page_index = IdxW'(base_page + $urandom_range(0, Window));
    end else if (roll < 45) begin
      r.command = CmdAllocPage;
    end else if (roll < 60) begin
      r.command = CmdAllocRun;
      if ($urandom_range(0, 9) == 0) r.run_length = LenW'($urandom_range(9, MaxRun));
      if ($urandom_range(0, 29) == 0) r.run_length = LenW'($urandom);
    end else if (roll < 82) begin
      r.command = CmdFreePage;
      if (held_pages.size() > 0 && $urandom_range(0, 4) != 0)
        r.page_index = IdxW'(held_pages[$urandom_range(0, held_pages.size() - 1)]);
    end else if (roll < 92) begin
      r.command = CmdStats;
    end else begin
      r.command = 3'($urandom_range(CmdSpare5, CmdSpare7));
    end
    // Keep full-range scans rare; the block walks one page per cycle.
    span = scan_span(r);
    if (span > CostlyScan) begin
      if (costly_left > 0) costly_left--;
      else r.command = CmdStats;
    end
    return r;
  endfunction

  initial begin
    dir_row_t    dir_rows[$];
    logic [IdxW-1:0] phase_low[$];
    int unsigned per_phase;
    // Known values on every input from time zero.
    rst_n     = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    in_valid  = 1'b0;
    in_req    = '0;
    no_stall  = 1'b0;
    no_gap    = 1'b0;
    mismatches  = 0;
    idle_cycles = 0;
    costly_left = 4;

    foreach (page_taken[i]) begin
      page_taken[i] = 1'b1;
      page_tag[i]   = '0;
    end
    foreach (tag_pages[i]) tag_pages[i] = '0;
    free_total   = '0;
    usable_total = '0;
    base_page    = LowPageRst;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table; fixed responses only where they are obvious.
    dir_rows.push_back(row(CmdStats, 3'd1, 0, 1, 1'b1, '{StOk, 16'd0, 17'd0, 17'd0, 17'd0}));
    dir_rows.push_back(row(CmdStats, 3'd0, 0, 1, 1'b1,
                           '{StBadUsage, 16'd0, 17'd0, 17'd0, 17'd0}));
    // Empty table: a full scan that finds nothing.
    dir_rows.push_back(row(CmdAllocPage, 3'd1, 0, 1, 1'b1,
                           '{StNoSpace, 16'd0, 17'd0, 17'd0, 17'd0}));
    // Free of a reserved page.
    dir_rows.push_back(row(CmdFreePage, 3'd1, 300, 1, 1'b1,
                           '{StNotAlloc, 16'd0, 17'd0, 17'd0, 17'd0}));
    dir_rows.push_back(row(CmdAddPage, 3'd1, 256, 0, 1'b1, '{StOk, 16'd0, 17'd0, 17'd1, 17'd1}));
    dir_rows.push_back(row(CmdAddPage, 3'd2, 257, 511));
    dir_rows.push_back(row(CmdAddPage, 3'd3, 258, 1));
    dir_rows.push_back(row(CmdAddPage, 3'd4, 259, 1));
    dir_rows.push_back(row(CmdAddPage, 3'd7, 65535, 256));
    dir_rows.push_back(row(CmdAddPage, 3'd0, 0, 1));     // below the low bound
    dir_rows.push_back(row(CmdAddPage, 3'd1, 256, 1));   // already free: ignored
    dir_rows.push_back(row(CmdAllocPage, 3'd7, 0, 1));
    dir_rows.push_back(row(CmdAllocPage, 3'd0, 0, 1));   // bad usage
    dir_rows.push_back(row(CmdAllocRun, 3'd2, 0, 0));    // zero length
    dir_rows.push_back(row(CmdAllocRun, 3'd2, 0, 257));  // beyond the longest run
    dir_rows.push_back(row(CmdAllocRun, 3'd2, 0, 511));
    dir_rows.push_back(row(CmdAllocRun, 3'd0, 0, 2));    // bad usage
    dir_rows.push_back(row(CmdAllocRun, 3'd2, 0, 3));
    dir_rows.push_back(row(CmdFreePage, 3'd0, 256, 1));  // usage plays no part
    dir_rows.push_back(row(CmdFreePage, 3'd5, 256, 1));  // now free: rejected
    dir_rows.push_back(row(CmdFreePage, 3'd5, 65535, 1)); // free page: rejected
    dir_rows.push_back(row(CmdSpare5, 3'd1, 0, 1));
    dir_rows.push_back(row(CmdSpare6, 3'd7, 65535, 511));
    dir_rows.push_back(row(CmdSpare7, 3'd0, 0, 0));
    dir_rows.push_back(row(CmdStats, 3'd7, 0, 1));

    foreach (dir_rows[i]) send_request(dir_rows[i].req, dir_rows[i].rsp, dir_rows[i].typed);

    // Random phases, each under its own low bound; extremes included.
    phase_low = '{16'd0, LowPageRst, 16'd1000, 16'd65535, 16'd30000,
                  IdxW'($urandom_range(0, 60000))};
    per_phase = 120;
    foreach (phase_low[p]) begin
      // Hold off until every response is in, then move the bound.
      drain_responses();
      write_low_page(phase_low[p]);
      no_stall = (p == 2);
      no_gap   = (p == 2) || (p == 4);
      repeat (per_phase) send_request(random_request(), '0, 1'b0);
    end

    in_valid <= 1'b0;
    wait (pending_rsps.size() == 0);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- page_frame_allocator.f -----
+incdir+rtl
rtl/pfa_pkg.sv
rtl/pfa_ram.sv
rtl/pfa_stats.sv
rtl/page_frame_allocator.sv
rtl/pfa_checker.sv
tb/page_frame_allocator_tb.sv
